// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

   // Request kinds carried on the request tuser
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Character codes
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BLANK     = 8'd32;

   // Color and blank cell after reset
   localparam logic [7:0]  RESET_COLOR = 8'd7;
   localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_BLANK};

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 8;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_READ,
      ST_READ_CAP,
      ST_SCROLL,
      ST_FILL,
      ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic home;
      logic put_step;
      logic read_capture;
      logic scroll_step;
      logic fill_step;
      logic init_fill;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scroll;
      logic scroll_last;
      logic fill_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== design/text_console_writer_top.sv =====
// Top level of the text console writer: stream ports, sequencer and datapath.
// Requests are taken one at a time: a new request is accepted only once the last
// response has been loaded, and a stalled response holds off the next request.
// A put that scrolls also copies each row one row up, then blanks the bottom row.
// Reset: synchronous; a pass over all ROWS*COLUMNS cells blanks the grid in color 7
// before requests are taken.
module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] cursor_pos, [26:11] cell_value,
                                    // [27] scrolled, rest zero
   // color register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // text_color
);

   cmd_type            cmd;
   status_type         status;
   logic [INDEX_W-1:0] cursor_pos;
   logic [CELL_W-1:0]  cell_value;
   logic               scrolled;

   // The color register takes a write in any cycle.
   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_type  (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_char      (req_tdata[7:0]),
      .req_index     (req_tdata[18:8]),
      .csr_we        (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_cursor_pos(cursor_pos),
      .rsp_cell_value(cell_value),
      .rsp_scrolled  (scrolled)
   );

   // Pack the response fields, lowest first, zero-fill to whole bytes.
   assign rsp_tdata = {4'b0, scrolled, cell_value, cursor_pos};

endmodule

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcw_ctrl.sv =====
// Request sequencer for the text console writer.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_type,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_PUT:   state_in = ST_PUT;
                  REQ_READ:  state_in = ST_READ;
                  REQ_CLEAR: state_in = ST_FILL;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_PUT: begin
            state_in = status.need_scroll ? ST_SCROLL : ST_RESP;
         end
         ST_READ:     state_in = ST_READ_CAP;
         ST_READ_CAP: state_in = ST_RESP;
         ST_SCROLL: begin
            if (status.scroll_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (status.fill_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_step = 1'b1;
            cmd.init_fill = 1'b1;
         end
         ST_IDLE: begin
            cmd.load_req = accept;
            cmd.home     = accept && (req_type == REQ_CLEAR);
         end
         ST_PUT:      cmd.put_step     = 1'b1;
         ST_READ:     cmd              = '0;
         ST_READ_CAP: cmd.read_capture = 1'b1;
         ST_SCROLL:   cmd.scroll_step  = 1'b1;
         ST_FILL:     cmd.fill_step    = 1'b1;
         ST_RESP:     cmd.rsp_load     = status.rsp_free;
         default:     cmd              = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/tcw_datapath.sv =====
// Cursor, color, grid memory and response register of the text console writer.
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [CHAR_W-1:0]  req_char,
   input  logic [INDEX_W-1:0] req_index,
   input  logic               csr_we,
   input  logic [COLOR_W-1:0] csr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [INDEX_W-1:0] rsp_cursor_pos,
   output logic [CELL_W-1:0]  rsp_cell_value,
   output logic               rsp_scrolled
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   logic [COLOR_W-1:0] color_ff, color_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               in_range_ff, in_range_in;
   logic [CELL_W-1:0]  value_ff, value_in;
   logic               scrolled_ff, scrolled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic [ADDR_W-1:0] cur_addr;
   logic [COL_W-1:0]  put_col;
   logic [ROW_W-1:0]  put_row;
   logic              put_we;
   logic              put_wrap;
   logic [ADDR_W-1:0] put_addr;
   logic [CELL_W-1:0] put_data;
   logic              need_scroll;
   logic              scroll_last;
   logic              fill_last;
   logic              rsp_free;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   assign cur_addr = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));

   // Put character: backspace, newline or any other byte
   always_comb begin
      put_col  = col_ff;
      put_we   = 1'b0;
      put_wrap = 1'b0;
      put_addr = cur_addr;
      put_data = {color_ff, char_ff};
      if (char_ff == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            put_col  = col_ff - COL_W'(1);
            put_we   = 1'b1;
            put_addr = cur_addr - ADDR_W'(1);
            put_data = {color_ff, CH_BLANK};
         end
      end else if (char_ff == CH_NEWLINE) begin
         put_col  = '0;
         put_wrap = 1'b1;
      end else begin
         put_we = 1'b1;
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            put_col  = '0;
            put_wrap = 1'b1;
         end else begin
            put_col = col_ff + COL_W'(1);
         end
      end
   end

   assign need_scroll = put_wrap && (row_ff == ROW_W'(ROWS - 1));
   assign put_row     = (put_wrap && !need_scroll) ? row_ff + ROW_W'(1) : row_ff;
   assign scroll_last = (sweep_ff == ADDR_W'(CELLS - COLUMNS));
   assign fill_last   = (sweep_ff == ADDR_W'(CELLS - 1));
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   assign status.need_scroll = need_scroll;
   assign status.scroll_last = scroll_last;
   assign status.fill_last   = fill_last;
   assign status.rsp_free    = rsp_free;

   // Grid memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = {color_ff, CH_BLANK};
      if (cmd.put_step) begin
         mem_we    = put_we;
         mem_waddr = put_addr;
         mem_wdata = put_data;
      end else if (cmd.scroll_step) begin
         // copy the cell below, read in the previous cycle, into the cell one row up
         mem_we    = (sweep_ff != '0);
         mem_waddr = sweep_ff - ADDR_W'(1);
         mem_wdata = mem_rdata;
      end else if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.init_fill ? RESET_CELL : {color_ff, CH_BLANK};
      end
   end

   assign mem_raddr = cmd.scroll_step ? ADDR_W'(32'(sweep_ff) + COLUMNS)
                                      : ADDR_W'(index_ff);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS),
      .ADDR_W(ADDR_W)
   ) u_grid (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // Next values
   always_comb begin
      color_in = csr_we ? csr_data : color_ff;

      row_in = row_ff;
      col_in = col_ff;
      if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.put_step) begin
         row_in = put_row;
         col_in = put_col;
      end

      sweep_in = sweep_ff;
      if (cmd.load_req) begin
         sweep_in = '0;
      end else if ((cmd.scroll_step && !scroll_last) || cmd.fill_step) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end

      char_in     = cmd.load_req ? req_char : char_ff;
      index_in    = cmd.load_req ? req_index : index_ff;
      in_range_in = cmd.load_req ? (32'(req_index) < CELLS) : in_range_ff;

      value_in = value_ff;
      if (cmd.load_req) begin
         value_in = '0;
      end else if (cmd.read_capture) begin
         value_in = in_range_ff ? mem_rdata : '0;
      end

      scrolled_in = scrolled_ff;
      if (cmd.load_req) begin
         scrolled_in = 1'b0;
      end else if (cmd.put_step) begin
         scrolled_in = need_scroll;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_pos_in      = rsp_pos_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      if (cmd.rsp_load) begin
         rsp_pos_in      = INDEX_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
         rsp_value_in    = value_ff;
         rsp_scrolled_in = scrolled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff         <= char_in;
      index_ff        <= index_in;
      in_range_ff     <= in_range_in;
      value_ff        <= value_in;
      scrolled_ff     <= scrolled_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule
